FILE: rtl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg: shared types, constants and helpers for the PID controller
// Payload structs, sequencer states, register indexes, unit widths and the
// 40-bit saturation helpers used by the top level.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int GAIN_W     = 16;
  localparam int PERIOD_W   = 8;
  localparam int DRV_W      = 16;
  localparam int ERR_W      = 17;
  localparam int TERM_W     = 40;
  localparam int SUM_W      = 42;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // shared multiplier
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 21;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  // serial divider
  localparam int DIV_STEPS  = 4;
  localparam int DVSR_W     = 21;
  localparam int REM_W      = DVSR_W + 1;
  localparam int QUOT_W     = 41;
  localparam int MAG_W      = 41;
  localparam int NUM_W      = 58;
  localparam int NUM_MAG_W  = 57;
  localparam int DIV_W_DEF  = 60;

  localparam logic [DVSR_W-1:0] DIV_PROP  = 21'd1000;
  localparam logic [DVSR_W-1:0] DIV_INTEG = 21'd2000000;
  localparam logic [DVSR_W-1:0] DIV_DERIV = 21'd100;

  localparam logic signed [SUM_W-1:0] SAT_HI = 42'sd549755813887;
  localparam logic signed [SUM_W-1:0] SAT_LO = -42'sd549755813888;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_DERIV_GAIN,
    CFG_FILTER_TAU,
    CFG_SAMPLE_PERIOD,
    CFG_DRIVE_MAX,
    CFG_DRIVE_MIN,
    CFG_INTEGRATE_ON
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_DIV_P,
    ST_WAIT_P,
    ST_MUL_IG,
    ST_MUL_I,
    ST_DIV_I,
    ST_WAIT_I,
    ST_INTEG,
    ST_CLAMP,
    ST_MUL_D,
    ST_DIV_D,
    ST_WAIT_D,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_NUM,
    ST_DIV_F,
    ST_WAIT_F,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] measured;
    logic signed [DRV_W-1:0] target;
  } pid_in_t;

  typedef struct packed {
    logic signed [DRV_W-1:0]  drive;
    logic signed [TERM_W-1:0] prop_term;
    logic signed [TERM_W-1:0] integ_term;
    logic signed [TERM_W-1:0] deriv_term;
  } pid_out_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  function automatic logic signed [TERM_W-1:0] sat40(input logic signed [SUM_W-1:0] v);
    logic signed [TERM_W-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[TERM_W-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[TERM_W-1:0];
    end else begin
      res = v[TERM_W-1:0];
    end
    return res;
  endfunction

  // apply sign to a quotient magnitude and saturate to the 40-bit range
  function automatic logic signed [TERM_W-1:0] sat_mag(input logic neg, input logic ovf,
                                                       input logic [QUOT_W-1:0] q);
    logic [QUOT_W-1:0]        nq;
    logic signed [TERM_W-1:0] res;
    nq = -q;
    if (neg) begin
      if (ovf || (q > 41'd549755813888)) begin
        res = SAT_LO[TERM_W-1:0];
      end else begin
        res = nq[TERM_W-1:0];
      end
    end else begin
      if (ovf || (q > 41'd549755813887)) begin
        res = SAT_HI[TERM_W-1:0];
      end else begin
        res = q[TERM_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/pidaw_mul.sv
// ----------------------------------------------------------------------------
// pidaw_mul: shared signed multiplier
// One 25 x 21 bit signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module pidaw_mul import pidaw_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [MUL_P_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

FILE: rtl/pidaw_div.sv
// ----------------------------------------------------------------------------
// pidaw_div: serial unsigned divider
// Restoring long division, DIV_STEPS dividend bits per cycle, with a
// 41-bit quotient and a sticky flag for quotient bits shifted out on top.
// ----------------------------------------------------------------------------
module pidaw_div import pidaw_pkg::*; #(
  parameter int DIV_W = DIV_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output div_res_t          res
);

  localparam int STEP_CNT = DIV_W / DIV_STEPS;
  localparam int CNT_W    = $clog2(STEP_CNT + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  dd_r;
  logic [REM_W-1:0]  rem_r;
  logic [QUOT_W-1:0] q_r;
  logic              ovf_r;
  logic [DVSR_W-1:0] divisor_r;

  logic [DIV_W-1:0]  dd_nxt;
  logic [REM_W-1:0]  rem_nxt;
  logic [QUOT_W-1:0] q_nxt;
  logic              ovf_nxt;

  always_comb begin
    logic [REM_W-1:0] trial;
    dd_nxt  = dd_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    ovf_nxt = ovf_r;
    trial   = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial   = {rem_nxt[REM_W-2:0], dd_nxt[DIV_W-1]};
      dd_nxt  = dd_nxt << 1;
      ovf_nxt = ovf_nxt | q_nxt[QUOT_W-1];
      if (trial >= {1'b0, divisor_r}) begin
        rem_nxt = trial - {1'b0, divisor_r};
        q_nxt   = {q_nxt[QUOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_nxt[QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEP_CNT);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dd_r      <= dividend;
      rem_r     <= '0;
      q_r       <= '0;
      ovf_r     <= 1'b0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      dd_r  <= dd_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = q_r;

endmodule

FILE: rtl/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// One item at a time: the next input is taken only after the result is loaded
// into the output register. Each item runs four divisions on the 4-bit-per-cycle
// divider (three when filter_tau and sample_period are both zero).
// Reset (synchronous, rst_n low): configuration to defaults, controller state cleared.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup import pidaw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pid_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pid_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DIV_W_MIN = (FRAC_BITS + MAG_W > NUM_MAG_W) ? FRAC_BITS + MAG_W : NUM_MAG_W;
  localparam int DIV_W     = ((DIV_W_MIN + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam logic signed [SUM_W-1:0] DRV_BIAS = (42'sd1 <<< FRAC_BITS) - 42'sd1;

  state_t state_r, state_nxt;

  // configuration
  logic [GAIN_W-1:0]          prop_gain_r;
  logic [GAIN_W-1:0]          integ_gain_r;
  logic [GAIN_W-1:0]          deriv_gain_r;
  logic [GAIN_W-1:0]          filter_tau_r;
  logic [PERIOD_W-1:0]        sample_period_r;
  logic signed [DRV_W-1:0]    drive_max_r;
  logic signed [DRV_W-1:0]    drive_min_r;
  logic                       integrate_on_r;

  // controller state
  logic signed [TERM_W-1:0]   integ_acc_r;
  logic signed [TERM_W-1:0]   deriv_acc_r;
  logic signed [ERR_W-1:0]    last_err_r;

  // working registers
  logic signed [ERR_W-1:0]    err_r;
  logic                       neg_r;
  logic signed [TERM_W-1:0]   p_r;
  logic signed [TERM_W-1:0]   inc_r;
  logic signed [TERM_W-1:0]   t1_r;
  logic signed [TERM_W-1:0]   d_r;
  logic signed [TERM_W-1:0]   acc_r;
  logic signed [TERM_W-1:0]   lim_hi_r;
  logic signed [TERM_W-1:0]   lim_lo_r;
  logic signed [NUM_W-1:0]    num_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic                       out_valid_r;
  pid_out_t                   out_data_r;

  // shared units
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod_r;
  logic                       div_start;
  logic [DIV_W-1:0]           div_dvd;
  logic [DVSR_W-1:0]          div_dvsr;
  div_res_t                   div_res;

  logic                       load_out;
  logic signed [ERR_W-1:0]    in_err;
  logic signed [ERR_W:0]      esum;
  logic signed [ERR_W:0]      ediff;
  logic signed [17:0]         coef;
  logic [17:0]                den;
  logic [MUL_P_W-1:0]         prod_mag;
  logic [NUM_W-1:0]           num_mag;
  logic [DIV_W-1:0]           scaled_dvd;
  logic [DIV_W-1:0]           num_dvd;
  logic signed [TERM_W-1:0]   quot_sat;
  logic signed [SUM_W-1:0]    acc_sum;
  logic signed [SUM_W-1:0]    dmax_sh;
  logic signed [SUM_W-1:0]    dmin_sh;
  logic signed [SUM_W-1:0]    p_x;
  logic signed [SUM_W-1:0]    hi_diff;
  logic signed [SUM_W-1:0]    lo_diff;
  logic signed [TERM_W-1:0]   clamp_val;
  logic signed [SUM_W-1:0]    sum_adj;
  logic signed [SUM_W-1:0]    drv_full;
  logic signed [SUM_W-1:0]    dmax_x;
  logic signed [SUM_W-1:0]    dmin_x;
  logic signed [DRV_W-1:0]    drv;

  pidaw_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  pidaw_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvsr),
    .res      (div_res)
  );

  assign in_err = {in_data.target[DRV_W-1], in_data.target}
                - {in_data.measured[DRV_W-1], in_data.measured};
  assign esum   = {err_r[ERR_W-1], err_r} + {last_err_r[ERR_W-1], last_err_r};
  assign ediff  = {err_r[ERR_W-1], err_r} - {last_err_r[ERR_W-1], last_err_r};
  assign coef   = $signed({1'b0, filter_tau_r, 1'b0}) - $signed({10'd0, sample_period_r});
  assign den    = {1'b0, filter_tau_r, 1'b0} + {10'd0, sample_period_r};

  assign prod_mag   = prod_r[MUL_P_W-1] ? MUL_P_W'(-prod_r) : MUL_P_W'(prod_r);
  assign num_mag    = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign scaled_dvd = {{(DIV_W-MAG_W){1'b0}}, prod_mag[MAG_W-1:0]} << FRAC_BITS;
  assign num_dvd    = {{(DIV_W-NUM_MAG_W){1'b0}}, num_mag[NUM_MAG_W-1:0]};
  assign quot_sat   = sat_mag(neg_r, div_res.ovf, div_res.quot);

  // integrator update and its anti-windup limits
  assign acc_sum = {{2{integ_acc_r[TERM_W-1]}}, integ_acc_r} + {{2{inc_r[TERM_W-1]}}, inc_r};
  assign dmax_sh = $signed({{(SUM_W-DRV_W){drive_max_r[DRV_W-1]}}, drive_max_r}) <<< FRAC_BITS;
  assign dmin_sh = $signed({{(SUM_W-DRV_W){drive_min_r[DRV_W-1]}}, drive_min_r}) <<< FRAC_BITS;
  assign p_x     = {{2{p_r[TERM_W-1]}}, p_r};
  assign hi_diff = dmax_sh - p_x;
  assign lo_diff = dmin_sh - p_x;

  always_comb begin
    priority if (acc_r > lim_hi_r) begin
      clamp_val = lim_hi_r;
    end else if (acc_r < lim_lo_r) begin
      clamp_val = lim_lo_r;
    end else begin
      clamp_val = acc_r;
    end
  end

  // truncate the sum toward zero, then clamp low limit first
  assign sum_adj  = sum_r + (sum_r[SUM_W-1] ? DRV_BIAS : '0);
  assign drv_full = sum_adj >>> FRAC_BITS;
  assign dmax_x   = {{(SUM_W-DRV_W){drive_max_r[DRV_W-1]}}, drive_max_r};
  assign dmin_x   = {{(SUM_W-DRV_W){drive_min_r[DRV_W-1]}}, drive_min_r};

  always_comb begin
    priority if (drv_full < dmin_x) begin
      drv = drive_min_r;
    end else if (drv_full > dmax_x) begin
      drv = drive_max_r;
    end else begin
      drv = drv_full[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = scaled_dvd;
    div_dvsr  = DIV_PROP;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        mul_a     = {9'd0, prop_gain_r};
        mul_b     = {{4{err_r[ERR_W-1]}}, err_r};
        state_nxt = ST_DIV_P;
      end
      ST_DIV_P: begin
        div_start = 1'b1;
        div_dvsr  = DIV_PROP;
        state_nxt = ST_WAIT_P;
      end
      ST_WAIT_P: begin
        if (div_res.done) state_nxt = ST_MUL_IG;
      end
      ST_MUL_IG: begin
        mul_a     = {9'd0, integ_gain_r};
        mul_b     = {13'd0, sample_period_r};
        state_nxt = ST_MUL_I;
      end
      ST_MUL_I: begin
        mul_a     = {1'b0, prod_r[23:0]};
        mul_b     = {{3{esum[ERR_W]}}, esum};
        state_nxt = ST_DIV_I;
      end
      ST_DIV_I: begin
        div_start = 1'b1;
        div_dvsr  = DIV_INTEG;
        state_nxt = ST_WAIT_I;
      end
      ST_WAIT_I: begin
        if (div_res.done) state_nxt = ST_INTEG;
      end
      ST_INTEG: state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_MUL_D;
      ST_MUL_D: begin
        mul_a     = {8'd0, deriv_gain_r, 1'b0};
        mul_b     = {{3{ediff[ERR_W]}}, ediff};
        state_nxt = ST_DIV_D;
      end
      ST_DIV_D: begin
        div_start = 1'b1;
        div_dvsr  = DIV_DERIV;
        state_nxt = ST_WAIT_D;
      end
      ST_WAIT_D: begin
        if (div_res.done) state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        mul_a     = {{7{coef[17]}}, coef};
        mul_b     = {1'b0, deriv_acc_r[19:0]};
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        mul_a     = {{7{coef[17]}}, coef};
        mul_b     = {deriv_acc_r[TERM_W-1], deriv_acc_r[TERM_W-1:20]};
        state_nxt = ST_NUM;
      end
      ST_NUM: state_nxt = ST_DIV_F;
      ST_DIV_F: begin
        // zero filter denominator: skip the division, term is zero
        if (den == '0) begin
          state_nxt = ST_SUM;
        end else begin
          div_start = 1'b1;
          div_dvd   = num_dvd;
          div_dvsr  = DVSR_W'(den);
          state_nxt = ST_WAIT_F;
        end
      end
      ST_WAIT_F: begin
        if (div_res.done) state_nxt = ST_SUM;
      end
      ST_SUM: state_nxt = ST_OUT;
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration, controller state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= 16'd1000;
      integ_gain_r    <= '0;
      deriv_gain_r    <= '0;
      filter_tau_r    <= 16'd10;
      sample_period_r <= 8'd1;
      drive_max_r     <= 16'sd32767;
      drive_min_r     <= -16'sd32768;
      integrate_on_r  <= 1'b1;
      integ_acc_r     <= '0;
      deriv_acc_r     <= '0;
      last_err_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_PROP_GAIN:     prop_gain_r     <= cfg_wdata;
          CFG_INTEG_GAIN:    integ_gain_r    <= cfg_wdata;
          CFG_DERIV_GAIN:    deriv_gain_r    <= cfg_wdata;
          CFG_FILTER_TAU:    filter_tau_r    <= cfg_wdata;
          CFG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata[PERIOD_W-1:0];
          CFG_DRIVE_MAX:     drive_max_r     <= cfg_wdata;
          CFG_DRIVE_MIN:     drive_min_r     <= cfg_wdata;
          CFG_INTEGRATE_ON:  integrate_on_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == ST_CLAMP) integ_acc_r <= clamp_val;
      if (load_out) begin
        deriv_acc_r <= d_r;
        last_err_r  <= err_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: err_r <= in_err;
      ST_DIV_P, ST_DIV_I, ST_DIV_D: neg_r <= prod_r[MUL_P_W-1];
      ST_WAIT_P: begin
        if (div_res.done) p_r <= quot_sat;
      end
      ST_WAIT_I: begin
        if (div_res.done) inc_r <= quot_sat;
      end
      ST_INTEG: begin
        acc_r    <= integrate_on_r ? sat40(acc_sum) : '0;
        lim_hi_r <= (hi_diff > 42'sd0) ? sat40(hi_diff) : '0;
        lim_lo_r <= (lo_diff < 42'sd0) ? sat40(lo_diff) : '0;
      end
      ST_WAIT_D: begin
        if (div_res.done) t1_r <= quot_sat;
      end
      ST_MUL_HI: begin
        num_r <= {{(NUM_W-TERM_W){t1_r[TERM_W-1]}}, t1_r}
               + {{(NUM_W-MUL_P_W){prod_r[MUL_P_W-1]}}, prod_r};
      end
      ST_NUM: num_r <= num_r + $signed({prod_r[37:0], 20'd0});
      ST_DIV_F: begin
        neg_r <= num_r[NUM_W-1];
        if (den == '0) d_r <= '0;
      end
      ST_WAIT_F: begin
        if (div_res.done) d_r <= quot_sat;
      end
      ST_SUM: sum_r <= p_x + {{2{integ_acc_r[TERM_W-1]}}, integ_acc_r}
                     + {{2{d_r[TERM_W-1]}}, d_r};
      ST_OUT: begin
        if (load_out) begin
          out_data_r.drive      <= drv;
          out_data_r.prop_term  <= p_r;
          out_data_r.integ_term <= integ_acc_r;
          out_data_r.deriv_term <= d_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_WAIT_P) || (state_r == ST_WAIT_I) ||
                     (state_r == ST_WAIT_D) || (state_r == ST_WAIT_F))
    else $error("divider finished outside a wait state");

  a_integ_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLAMP |=> (integ_acc_r <= lim_hi_r) && (integ_acc_r >= lim_lo_r))
    else $error("integrator outside anti-windup limits");
`endif

endmodule
